// ----- rtl/md5_pkg.sv -----
// ----------------------------------------------------------------------------
// MD5 package
// Shared types, round constants and index helpers for the MD5 digest block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_FINAL
	} fsm_state_t;

	// Working variables of the compression.
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} work_t;

	// Byte write into the block buffer.
	typedef struct packed {
		logic       en;
		logic [3:0] addr;
		logic [1:0] lane;
		logic [7:0] data;
	} buf_wr_t;

	localparam logic [31:0] CHAIN_INIT [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam logic [7:0] PAD_MARK     = 8'h80;
	localparam logic [7:0] VER_KEEP     = 8'h0f;
	localparam logic [7:0] VER_SET      = 8'h30;
	localparam logic [7:0] VARIANT_KEEP = 8'h3f;
	localparam logic [7:0] VARIANT_SET  = 8'h80;
	localparam logic [5:0] LAST_ROUND   = 6'd63;
	localparam logic [5:0] LAST_BYTE    = 6'd63;

	localparam logic [31:0] RND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// Rotate amounts, indexed by {round group, round mod 4}.
	localparam logic [4:0] RND_S [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22,
		5'd5, 5'd9,  5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23,
		5'd6, 5'd10, 5'd15, 5'd21
	};

	// Message word used in a given round.
	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [3:0] r4;
		logic [3:0] idx;
		r4 = rnd[3:0];
		case (rnd[5:4])
			2'd0:    idx = r4;
			2'd1:    idx = 4'(r4 * 4'd5 + 4'd1);
			2'd2:    idx = 4'(r4 * 4'd3 + 4'd5);
			default: idx = 4'(r4 * 4'd7);
		endcase
		return idx;
	endfunction

	// Byte swap: little-endian chaining word to digest byte order.
	function automatic logic [31:0] bswap(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

`default_nettype wire

// ----- rtl/md5_buf.sv -----
// ----------------------------------------------------------------------------
// MD5 block buffer
// 16 x 32-bit message memory with byte writes and a registered word read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md5_buf (
	input  wire logic            clk,
	input  wire md5_pkg::buf_wr_t wr,
	input  wire logic [3:0]      rd_addr,
	output logic      [31:0]     rd_data
);

	logic [31:0] mem [16];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr][{wr.lane, 3'b000} +: 8] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ----- rtl/md5_round.sv -----
// ----------------------------------------------------------------------------
// MD5 round unit
// One compression round, shared by all 64 rounds of a block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md5_round (
	input  wire logic [5:0]  rnd,
	input  wire md5_pkg::work_t cur,
	input  wire logic [31:0] w,
	output md5_pkg::work_t   nxt
);

	logic [31:0] f;
	logic [31:0] sum;
	logic [63:0] dbl;
	logic [4:0]  amt;

	always_comb begin
		case (rnd[5:4])
			2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
			2'd1:    f = (cur.d & cur.b) | (~cur.d & cur.c);
			2'd2:    f = cur.b ^ cur.c ^ cur.d;
			default: f = cur.c ^ (cur.b | ~cur.d);
		endcase
		amt   = md5_pkg::RND_S[{rnd[5:4], rnd[1:0]}];
		sum   = cur.a + f + md5_pkg::RND_K[rnd] + w;
		dbl   = {sum, sum} << amt;
		nxt.a = cur.d;
		nxt.d = cur.c;
		nxt.c = cur.b;
		nxt.b = cur.b + dbl[63:32];
	end

endmodule

`default_nettype wire

// ----- rtl/md5_message_digest.sv -----
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-stream MD5 hasher with padding, length append and optional UUID marks.
// ----------------------------------------------------------------------------
//
//   channel   signals                                  direction
//   in        in_valid/in_ready, data_byte,            to block
//             byte_valid, last
//   out       out_valid/out_ready, digest_first,       from block
//             digest_second
//   cfg       cfg_wr_en, cfg_wr_data (uuid_form)       to block
//
// An ordinary byte item is taken in the idle state. The item that fills the
// 64-byte buffer starts the compression: a load step, 64 rounds on the single
// shared round unit and a step to fold the result into the chain.
// A last item pads one byte per cycle up to the block end, then compresses;
// with 56 or more bytes pending it needs a second padded block. Its worst case,
// 56 bytes pending, runs: the accepting step, padding, the first compression,
// padding of the second block, the second compression and the digest load.
// The input is not ready while a block is padded or compressed.
// Reset is asynchronous and loads the initial chaining words; no clearing
// pass is needed. The input stays ready while a digest waits on the output
// register, but a new digest waits until the previous one has been taken.
//
`timescale 1ns / 1ps
`default_nettype none

module md5_message_digest (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [63:0] digest_first,
	output logic      [63:0] digest_second,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data
);

	md5_pkg::fsm_state_t state_q, state_d;

	logic [5:0]  fill_q;
	logic [60:0] byte_cnt_q;
	logic [31:0] ch_q [4];
	md5_pkg::work_t work_q, work_nxt;
	logic [5:0]  rnd_q;
	logic [5:0]  pos_q;
	logic        mark_q;
	logic        len_blk_q;
	logic        pad_act_q;
	logic        last_pend_q;
	logic        uuid_q;
	logic        out_valid_q;
	logic [63:0] dig_first_q, dig_second_q;

	md5_pkg::buf_wr_t buf_wr;
	logic [3:0]  rd_addr;
	logic [31:0] w_word;

	logic        in_acc;
	logic        out_load;
	logic [5:0]  fill_inc;
	logic [5:0]  pad_start;
	logic [63:0] len_bits;
	logic [7:0]  pad_byte;
	logic [63:0] dig_first, dig_second;

	assign in_acc    = in_valid && in_ready;
	assign fill_inc  = fill_q + 6'd1;
	assign pad_start = byte_valid ? fill_inc : fill_q;
	assign len_bits  = {byte_cnt_q, 3'b000};
	assign out_load  = (state_q == md5_pkg::ST_FINAL) && (!out_valid_q || out_ready);

	// Padding byte: the end mark first, then zeros, and the bit length in the
	// last eight bytes of the final block.
	always_comb begin
		if (mark_q) begin
			pad_byte = md5_pkg::PAD_MARK;
		end else if (len_blk_q && (pos_q[5:3] == 3'b111)) begin
			pad_byte = len_bits[{pos_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	// Digest bytes in output order, with the UUID version and variant marks.
	always_comb begin
		dig_first  = {md5_pkg::bswap(ch_q[0]), md5_pkg::bswap(ch_q[1])};
		dig_second = {md5_pkg::bswap(ch_q[2]), md5_pkg::bswap(ch_q[3])};
		if (uuid_q) begin
			dig_first[15:8]   = (dig_first[15:8] & md5_pkg::VER_KEEP) | md5_pkg::VER_SET;
			dig_second[63:56] = (dig_second[63:56] & md5_pkg::VARIANT_KEEP) |
				md5_pkg::VARIANT_SET;
		end
	end

	// Sequencer: next state, input ready, buffer write and read address.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		buf_wr   = '0;
		rd_addr  = (state_q == md5_pkg::ST_ROUND) ? md5_pkg::msg_index(rnd_q + 6'd1) : 4'd0;
		case (state_q)
			md5_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					buf_wr.en   = byte_valid;
					buf_wr.addr = fill_q[5:2];
					buf_wr.lane = fill_q[1:0];
					buf_wr.data = data_byte;
					if (byte_valid && (fill_inc == 6'd0)) begin
						state_d = md5_pkg::ST_LOAD;
					end else if (last) begin
						state_d = md5_pkg::ST_PAD;
					end
				end
			end
			md5_pkg::ST_LOAD: begin
				state_d = md5_pkg::ST_ROUND;
			end
			md5_pkg::ST_ROUND: begin
				if (rnd_q == md5_pkg::LAST_ROUND) begin
					state_d = md5_pkg::ST_ADD;
				end
			end
			md5_pkg::ST_ADD: begin
				if (pad_act_q) begin
					state_d = len_blk_q ? md5_pkg::ST_FINAL : md5_pkg::ST_PAD;
				end else if (last_pend_q) begin
					state_d = md5_pkg::ST_PAD;
				end else begin
					state_d = md5_pkg::ST_IDLE;
				end
			end
			md5_pkg::ST_PAD: begin
				buf_wr.en   = 1'b1;
				buf_wr.addr = pos_q[5:2];
				buf_wr.lane = pos_q[1:0];
				buf_wr.data = pad_byte;
				if (pos_q == md5_pkg::LAST_BYTE) begin
					state_d = md5_pkg::ST_LOAD;
				end
			end
			md5_pkg::ST_FINAL: begin
				if (!out_valid_q || out_ready) begin
					state_d = md5_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = md5_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Message bookkeeping, chaining words and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			byte_cnt_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				ch_q[i] <= md5_pkg::CHAIN_INIT[i];
			end
			rnd_q       <= '0;
			pos_q       <= '0;
			mark_q      <= 1'b0;
			len_blk_q   <= 1'b0;
			pad_act_q   <= 1'b0;
			last_pend_q <= 1'b0;
			uuid_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				uuid_q <= cfg_wr_data;
			end
			if (in_acc) begin
				if (byte_valid) begin
					fill_q     <= fill_inc;
					byte_cnt_q <= byte_cnt_q + 61'd1;
				end
				if (last) begin
					last_pend_q <= 1'b1;
					pos_q       <= pad_start;
					mark_q      <= 1'b1;
					len_blk_q   <= (pad_start[5:3] != 3'b111);
				end
			end
			case (state_q)
				md5_pkg::ST_LOAD: begin
					rnd_q <= '0;
				end
				md5_pkg::ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
				end
				md5_pkg::ST_ADD: begin
					ch_q[0] <= ch_q[0] + work_q.a;
					ch_q[1] <= ch_q[1] + work_q.b;
					ch_q[2] <= ch_q[2] + work_q.c;
					ch_q[3] <= ch_q[3] + work_q.d;
					// The first of two padded blocks is done; the next carries the length.
					if (pad_act_q && !len_blk_q) begin
						len_blk_q <= 1'b1;
					end
				end
				md5_pkg::ST_PAD: begin
					pad_act_q <= 1'b1;
					pos_q     <= pos_q + 6'd1;
					mark_q    <= 1'b0;
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
				for (int i = 0; i < 4; i++) begin
					ch_q[i] <= md5_pkg::CHAIN_INIT[i];
				end
				fill_q      <= '0;
				byte_cnt_q  <= '0;
				last_pend_q <= 1'b0;
				pad_act_q   <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working variables and digest payload.
	always_ff @(posedge clk) begin
		if (state_q == md5_pkg::ST_LOAD) begin
			work_q <= '{a: ch_q[0], b: ch_q[1], c: ch_q[2], d: ch_q[3]};
		end else if (state_q == md5_pkg::ST_ROUND) begin
			work_q <= work_nxt;
		end
		if (out_load) begin
			dig_first_q  <= dig_first;
			dig_second_q <= dig_second;
		end
	end

	md5_buf u_buf (
		.clk     (clk),
		.wr      (buf_wr),
		.rd_addr (rd_addr),
		.rd_data (w_word)
	);

	md5_round u_round (
		.rnd (rnd_q),
		.cur (work_q),
		.w   (w_word),
		.nxt (work_nxt)
	);

	assign out_valid     = out_valid_q;
	assign digest_first  = dig_first_q;
	assign digest_second = dig_second_q;

endmodule

`default_nettype wire

// ----- rtl/md5_checker.sv -----
// ----------------------------------------------------------------------------
// MD5 port checker
// Port-level assertions on the MD5 digest block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module md5_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        byte_valid,
	input wire logic        last,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] digest_first,
	input wire logic [63:0] digest_second
);

	// A digest that is not taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_first) &&
		$stable(digest_second))
		else $error("digest changed or dropped while stalled");

	// An empty item that does not end the message keeps the block ready.
	a_empty_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !byte_valid && !last |=> in_ready)
		else $error("block went busy on an empty item");

	// The end of a message always makes the block busy, with padding or first a compression.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> !in_ready)
		else $error("block stayed ready after a last item");

	// A new digest appears only at the end of a busy stretch.
	a_digest_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("digest appeared without compression work");

endmodule

bind md5_message_digest md5_checker u_md5_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.byte_valid    (byte_valid),
	.last          (last),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.digest_first  (digest_first),
	.digest_second (digest_second)
);

`default_nettype wire

// ----- bench/md5_message_digest_test.sv -----
// ----------------------------------------------------------------------------
// MD5 message digest testbench
// Streams byte messages of many lengths into the hasher, predicts each digest
// with a local MD5 model and checks every digest that the block hands back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module md5_message_digest_test;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int ITEM_TARGET   = 1650;
	localparam int DIGEST_TARGET = 40;
	localparam int MSGS_PER_PASS = 8;
	localparam int DRAIN_CYCLES  = 300;   // longer than the worst last item takes
	localparam int HOLD_CYCLES   = 2500;
	localparam int DIRECTED_ROWS = 20;

	// Additive constants and rotate amounts of the 64 MD5 rounds.
	localparam logic [31:0] ROUND_ADD [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam logic [4:0] ROT_BY [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};
	localparam logic [31:0] HASH_SEED [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};
	localparam logic [7:0] END_MARK     = 8'h80;
	localparam logic [7:0] VERSION_MASK = 8'h0f;
	localparam logic [7:0] VERSION_3    = 8'h30;
	localparam logic [7:0] VARIANT_MASK = 8'h3f;
	localparam logic [7:0] VARIANT_IETF = 8'h80;

	typedef struct packed {
		logic [63:0] first;
		logic [63:0] second;
	} digest_t;

	// A directed row is either one item for the input channel or a write of
	// the UUID register, which happens only once the block has gone quiet.
	typedef enum logic {ROW_ITEM, ROW_UUID} row_kind_t;
	typedef struct packed {
		row_kind_t   kind;
		logic        uuid;
		logic [7:0]  data;
		logic        bval;
		logic        lst;
		logic        known;
		logic [63:0] first;
		logic [63:0] second;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_valid = 1'b0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] digest_first;
	logic [63:0] digest_second;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;

	// Local copy of the hasher state.
	logic [31:0] hash_words [4];
	logic [7:0]  blk_bytes [64];
	logic [5:0]  fill_pos;
	logic [60:0] msg_bytes;
	logic        uuid_mode;

	digest_t     pending_digests [$];
	stim_row_t   directed_rows [DIRECTED_ROWS];
	int          error_count = 0;
	int          cycle_count = 0;
	int          item_count = 0;
	int          digests_sent = 0;
	int          hold_asked = 0;
	bit          steady = 1'b0;
	bit          brief_msgs = 1'b0;

	md5_message_digest u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.digest_first (digest_first),
		.digest_second(digest_second),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Runaway guard: a correct run finishes far below this count.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch in %s at cycle %0d: got %h, expected %h",
			what, cycle_count, got, want);
		error_count++;
	endtask

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		return (x << n) | (x >> (6'd32 - n));
	endfunction

	function automatic void restart_hash();
		for (int k = 0; k < 4; k++)
			hash_words[k] = HASH_SEED[k];
		fill_pos = '0;
		msg_bytes = '0;
	endfunction

	// One 64-round compression of the 64-byte buffer into the chaining words.
	function automatic void compress_block();
		logic [31:0] w [16];
		logic [31:0] va, vb, vc, vd, f, t;
		int g;
		for (int k = 0; k < 16; k++)
			w[k] = {blk_bytes[4*k+3], blk_bytes[4*k+2], blk_bytes[4*k+1], blk_bytes[4*k]};
		va = hash_words[0];
		vb = hash_words[1];
		vc = hash_words[2];
		vd = hash_words[3];
		for (int r = 0; r < 64; r++) begin
			case (r / 16)
				0: begin
					f = (vb & vc) | (~vb & vd);
					g = r;
				end
				1: begin
					f = (vd & vb) | (~vd & vc);
					g = (5 * r + 1) % 16;
				end
				2: begin
					f = vb ^ vc ^ vd;
					g = (3 * r + 5) % 16;
				end
				default: begin
					f = vc ^ (vb | ~vd);
					g = (7 * r) % 16;
				end
			endcase
			t = vd;
			vd = vc;
			vc = vb;
			vb = vb + rotl32(va + f + ROUND_ADD[r] + w[g], ROT_BY[(r / 16) * 4 + r % 4]);
			va = t;
		end
		hash_words[0] += va;
		hash_words[1] += vb;
		hash_words[2] += vc;
		hash_words[3] += vd;
	endfunction

	// Takes one item into the local hasher; on a last item it pads, appends
	// the bit length, finishes the digest and starts over for the next message.
	function automatic void absorb_item(input logic [7:0] b, input logic bv, input logic lst,
			output logic got, output digest_t dg);
		logic [63:0] bit_len;
		logic [7:0]  dig [16];
		got = 1'b0;
		dg = '0;
		if (bv) begin
			blk_bytes[fill_pos] = b;
			fill_pos = fill_pos + 6'd1;
			msg_bytes = msg_bytes + 61'd1;
			if (fill_pos == 6'd0)
				compress_block();
		end
		if (!lst)
			return;
		bit_len = {msg_bytes, 3'b000};
		blk_bytes[fill_pos] = END_MARK;
		for (int k = int'(fill_pos) + 1; k < 64; k++)
			blk_bytes[k] = 8'h00;
		// With 56 or more bytes pending the length no longer fits: one extra block.
		if (fill_pos >= 6'd56) begin
			compress_block();
			for (int k = 0; k < 56; k++)
				blk_bytes[k] = 8'h00;
		end
		for (int k = 0; k < 8; k++)
			blk_bytes[56 + k] = bit_len[8*k +: 8];
		compress_block();
		for (int k = 0; k < 16; k++)
			dig[k] = hash_words[k / 4][8 * (k % 4) +: 8];
		if (uuid_mode) begin
			dig[6] = (dig[6] & VERSION_MASK) | VERSION_3;
			dig[8] = (dig[8] & VARIANT_MASK) | VARIANT_IETF;
		end
		for (int k = 0; k < 8; k++) begin
			dg.first = {dg.first[55:0], dig[k]};
			dg.second = {dg.second[55:0], dig[8 + k]};
		end
		got = 1'b1;
		restart_hash();
	endfunction

	// Offers one item, waits for the handshake and books its digest, if any.
	// A known digest from the directed table replaces the predicted one.
	task automatic send_item(input logic [7:0] b, input logic bv, input logic lst,
			input logic known = 1'b0, input digest_t typed = '0);
		logic    got;
		digest_t dg;
		digest_t booked;
		if (!steady) begin
			while ($urandom_range(99) < 16) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		data_byte <= b;
		byte_valid <= bv;
		last <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		absorb_item(b, bv, lst, got, dg);
		if (bv || lst)
			item_count++;
		if (got) begin
			booked = known ? typed : dg;
			pending_digests.insert(pending_digests.size(), booked);
			digests_sent++;
		end
	endtask

	// Drops valid and waits until every digest is back, then lets the block
	// run out whatever work it may still have.
	task automatic await_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_digests.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_uuid(input logic v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		uuid_mode = v;
	endtask

	// Message lengths favor short messages, with the padding edges around 55,
	// 56 and 64 bytes, multi-block messages and a few long ones.
	function automatic int pick_msg_len(input bit brief);
		int sel;
		int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
		sel = $urandom_range(99);
		if (brief)
			return $urandom_range(12);
		if (sel < 35)
			return $urandom_range(8);
		else if (sel < 70)
			return $urandom_range(60, 9);
		else if (sel < 85)
			return edges[$urandom_range(9)];
		else if (sel < 97)
			return $urandom_range(160, 65);
		return $urandom_range(300, 200);
	endfunction

	// A message is its bytes, now and then an ignored item in between, and
	// a last that rides on the final byte or comes as an item of its own.
	task automatic send_message(input int len);
		bit split_end;
		split_end = (len == 0) || ($urandom_range(99) < 30);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(99) < 5)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, (k == len - 1) && !split_end);
		end
		if (split_end)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// Output side: checks each digest against the oldest booked one and
	// drives out_ready, with one long hold-off when the stimulus asks for it.
	initial begin : digest_sink
		digest_t want;
		int      hold_seen;
		int      hold_left;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_digests.size() == 0) begin
					report_mismatch("digest with none pending", digest_first, '0);
				end else begin
					want = pending_digests.pop_front();
					if (digest_first !== want.first)
						report_mismatch("digest_first", digest_first, want.first);
					if (digest_second !== want.second)
						report_mismatch("digest_second", digest_second, want.second);
				end
			end
			if (hold_seen != hold_asked) begin
				hold_seen = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 16);
			end
		end
	end

	initial begin : stimulus
		stim_row_t row;
		int        pass_no;
		// Directed part: known digests of the empty message and "abc" in both
		// register settings and of "a" with the marks off, ignored items, a last
		// with no byte and the byte extremes.
		directed_rows = '{
			'{ROW_UUID, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
			'{ROW_ITEM, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1,
				64'hd41d8cd98f00b204, 64'he9800998ecf8427e},
			'{ROW_ITEM, 1'b0, 8'h5a, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
			'{ROW_ITEM, 1'b0, 8'h61, 1'b1, 1'b1, 1'b1,
				64'h0cc175b9c0f1b6a8, 64'h31c399e269772661},
			'{ROW_ITEM, 1'b0, 8'h61, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
			'{ROW_ITEM, 1'b0, 8'ha5, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
			'{ROW_ITEM, 1'b0, 8'h62, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
			'{ROW_ITEM, 1'b0, 8'h63, 1'b1, 1'b1, 1'b1,
				64'h900150983cd24fb0, 64'hd6963f7d28e17f72},
			'{ROW_ITEM, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
			'{ROW_ITEM, 1'b0, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
			'{ROW_ITEM, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
			'{ROW_UUID, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
			'{ROW_ITEM, 1'b0, 8'hff, 1'b0, 1'b1, 1'b1,
				64'hd41d8cd98f003204, 64'ha9800998ecf8427e},
			'{ROW_ITEM, 1'b0, 8'hff, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
			'{ROW_ITEM, 1'b0, 8'h61, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
			'{ROW_ITEM, 1'b0, 8'h62, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
			'{ROW_ITEM, 1'b0, 8'h63, 1'b1, 1'b1, 1'b1,
				64'h900150983cd23fb0, 64'h96963f7d28e17f72},
			'{ROW_UUID, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
			'{ROW_ITEM, 1'b0, 8'h80, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
			'{ROW_ITEM, 1'b0, 8'h7f, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0}
		};
		for (int k = 0; k < 64; k++)
			blk_bytes[k] = 8'h00;
		restart_hash();
		uuid_mode = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < DIRECTED_ROWS; n++) begin
			row = directed_rows[n];
			if (row.kind == ROW_UUID) begin
				await_quiet();
				write_uuid(row.uuid);
			end else begin
				send_item(row.data, row.bval, row.lst, row.known, {row.first, row.second});
			end
		end

		// Random part in passes of a few messages. Each pass starts from a
		// quiet block with its own register value. The third pass runs with
		// no idling on either side; the fourth sends short messages while
		// the output is held off, so that digests back up and input stalls.
		item_count = 0;
		digests_sent = 0;
		pass_no = 0;
		while (item_count < ITEM_TARGET || digests_sent < DIGEST_TARGET) begin
			await_quiet();
			if (pass_no < 2)
				write_uuid(pass_no == 0);
			else
				write_uuid($urandom_range(1));
			steady = (pass_no == 2);
			brief_msgs = (pass_no == 3);
			if (brief_msgs)
				hold_asked <= hold_asked + 1;
			repeat (MSGS_PER_PASS) send_message(pick_msg_len(brief_msgs));
			pass_no++;
		end

		await_quiet();
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
